@@ src/multi_threshold_idle_notifier_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multi-threshold idle notifier
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_THRESHOLD_IDLE_NOTIFIER_DEFINES_SVH
`define MULTI_THRESHOLD_IDLE_NOTIFIER_DEFINES_SVH

// Same-cycle implication.
`define MTIN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTIN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mtin_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-threshold idle notifier package
// Sizes, codes, transaction types and controller interface structs.
// ----------------------------------------------------------------------------
package mtin_pkg;

  localparam int TABLE_DEPTH   = 16;
  localparam int MS_PER_SECOND = 1000;

  localparam int ID_W      = 8;
  localparam int THR_W     = 24;
  localparam int AMT_W     = 32;
  localparam int IDLE_MS_W = 40;
  localparam int SWITCH_W  = 25;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int DIV_STEP   = 4;
  localparam int DIV_ITERS  = IDLE_MS_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS + 1);
  localparam int REM_W      = $clog2(MS_PER_SECOND) + 2;

  localparam logic [SWITCH_W-1:0] NONE_PENDING = '1;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_ACTIVITY = 2'd2,
    KIND_TICK     = 2'd3
  } mtin_kind_e;

  typedef enum logic [1:0] {
    EV_STATUS = 2'd0,
    EV_IDLE   = 2'd1,
    EV_ACTIVE = 2'd2
  } mtin_event_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_BAD_ARG   = 2'd3
  } mtin_status_e;

  typedef struct packed {
    mtin_kind_e       kind;
    logic [ID_W-1:0]  watcher_id;
    logic [THR_W-1:0] threshold_s;
    logic [AMT_W-1:0] amount_ms;
  } mtin_in_t;

  typedef struct packed {
    logic [ID_W-1:0]  watcher_id_out;
    mtin_event_e      event_res;
    logic [AMT_W-1:0] reported_s;
    mtin_status_e     status;
    logic             last;
  } mtin_res_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [THR_W-1:0] thr;
    logic             idle;
  } mtin_entry_t;

  typedef struct packed {
    logic load;
    logic add;
    logic rm_step;
    logic rm_done;
    logic div_start;
    logic scan_init;
    logic scan_step;
    logic emit;
  } mtin_cmd_t;

  typedef struct packed {
    logic any_idle;
    logic is_tick;
    logic req_bad;
    logic found;
    logic scan_done;
    logic div_busy;
    logic tick_due;
    logic match_none;
    logic match_one;
  } mtin_sts_t;

endpackage

@@ src/mtin_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant divisor divider
// Restoring division of the idle time by the milliseconds per second,
// several quotient bits per cycle.
// ----------------------------------------------------------------------------
module mtin_div
  import mtin_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [IDLE_MS_W-1:0] dividend_i,
  output logic                 busy_o,
  output logic [IDLE_MS_W-1:0] quotient_o
);

  logic [IDLE_MS_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int s = 0; s < DIV_STEP; s++) begin
      rem_d = {rem_d[REM_W-2:0], quo_d[IDLE_MS_W-1]};
      quo_d = {quo_d[IDLE_MS_W-2:0], 1'b0};
      if (rem_d >= REM_W'(MS_PER_SECOND)) begin
        rem_d    = rem_d - REM_W'(MS_PER_SECOND);
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(DIV_ITERS);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
      busy_q <= (cnt_q != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ src/mtin_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle notifier datapath
// Watcher table, idle time, pending switch point, match vector, divider and
// result register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module mtin_datapath
  import mtin_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mtin_in_t  in_i,
  input  mtin_cmd_t cmd_i,
  output mtin_sts_t sts_o,
  output logic      res_valid_o,
  output mtin_res_t res_o
);

  mtin_in_t             req_q;
  mtin_entry_t          table_q [TABLE_DEPTH];
  logic [CNT_W-1:0]     cnt_q;
  logic [IDLE_MS_W-1:0] idle_ms_q;
  logic                 any_idle_q;
  logic [SWITCH_W-1:0]  nss_q;
  logic [TABLE_DEPTH-1:0] match_q;
  logic [CNT_W-1:0]     scan_k_q;
  logic                 found_q;
  logic                 res_valid_q;
  mtin_res_t            res_q, res_d;

  logic [IDLE_MS_W:0]   idle_sum;
  logic [IDLE_MS_W-1:0] div_dividend;
  logic                 div_busy;
  logic [IDLE_MS_W-1:0] secs;
  logic [AMT_W-1:0]     secs_sat;
  logic [IDX_W-1:0]     hi_idx;
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     rd_idx;
  mtin_entry_t          rd_entry;
  logic                 is_tick;
  logic                 req_bad;
  logic                 entry_due;
  logic                 rm_hit;
  mtin_status_e         add_status;
  mtin_status_e         rm_status;

  assign is_tick  = (req_q.kind == KIND_TICK);
  assign req_bad  = (req_q.watcher_id == '0) || (req_q.threshold_s == '0);
  assign scan_idx = scan_k_q[IDX_W-1:0];
  assign rd_idx   = cmd_i.emit ? hi_idx : scan_idx;
  assign rd_entry = table_q[rd_idx];

  assign entry_due = (IDLE_MS_W'(rd_entry.thr) <= secs);
  assign rm_hit    = (rd_entry.id == req_q.watcher_id) && (rd_entry.thr == req_q.threshold_s);

  assign idle_sum     = {1'b0, idle_ms_q} + (IDLE_MS_W + 1)'(in_i.amount_ms);
  assign div_dividend = is_tick ? idle_ms_q : IDLE_MS_W'(req_q.amount_ms);
  assign secs_sat     = (|secs[IDLE_MS_W-1:AMT_W]) ? '1 : secs[AMT_W-1:0];

  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_q[i]) begin
        hi_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (req_bad) begin
      add_status = STS_BAD_ARG;
    end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
      add_status = STS_FULL;
    end else begin
      add_status = STS_OK;
    end
    if (req_bad) begin
      rm_status = STS_BAD_ARG;
    end else if (found_q) begin
      rm_status = STS_OK;
    end else begin
      rm_status = STS_NOT_FOUND;
    end
  end

  always_comb begin
    res_d                = res_q;
    res_d.watcher_id_out = req_q.watcher_id;
    res_d.event_res      = EV_STATUS;
    res_d.reported_s     = '0;
    res_d.last           = 1'b1;
    if (cmd_i.add) begin
      res_d.status = add_status;
    end else if (cmd_i.rm_done) begin
      res_d.status = rm_status;
    end else begin
      res_d.watcher_id_out = rd_entry.id;
      res_d.event_res      = is_tick ? EV_IDLE : EV_ACTIVE;
      res_d.reported_s     = secs_sat;
      res_d.status         = STS_OK;
      res_d.last           = sts_o.match_one;
    end
  end

  mtin_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .quotient_o (secs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idle_ms_q   <= '0;
      any_idle_q  <= 1'b0;
      nss_q       <= NONE_PENDING;
      match_q     <= '0;
      scan_k_q    <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.add | cmd_i.rm_done | cmd_i.emit;
      if (cmd_i.load) begin
        scan_k_q <= '0;
        found_q  <= 1'b0;
        if (in_i.kind == KIND_TICK) begin
          idle_ms_q <= idle_sum[IDLE_MS_W] ? '1 : idle_sum[IDLE_MS_W-1:0];
        end else if (in_i.kind == KIND_ACTIVITY) begin
          idle_ms_q <= IDLE_MS_W'(in_i.amount_ms);
        end
      end
      if (cmd_i.add && (add_status == STS_OK)) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if ({1'b0, req_q.threshold_s} < nss_q) begin
          nss_q <= {1'b0, req_q.threshold_s};
        end
      end
      if (cmd_i.rm_step) begin
        if (rm_hit) begin
          found_q <= 1'b1;
          cnt_q   <= cnt_q - CNT_W'(1);
        end else begin
          scan_k_q <= scan_k_q + CNT_W'(1);
        end
      end
      if (cmd_i.scan_init) begin
        nss_q    <= NONE_PENDING;
        match_q  <= '0;
        scan_k_q <= '0;
        if (!is_tick) begin
          any_idle_q <= 1'b0;
        end
      end
      if (cmd_i.scan_step) begin
        scan_k_q <= scan_k_q + CNT_W'(1);
        if (is_tick) begin
          if (!rd_entry.idle) begin
            if (entry_due) begin
              match_q[scan_idx] <= 1'b1;
              any_idle_q        <= 1'b1;
            end else if ({1'b0, rd_entry.thr} < nss_q) begin
              nss_q <= {1'b0, rd_entry.thr};
            end
          end
        end else begin
          if (rd_entry.idle) begin
            match_q[scan_idx] <= 1'b1;
          end
          if ({1'b0, rd_entry.thr} < nss_q) begin
            nss_q <= {1'b0, rd_entry.thr};
          end
        end
      end
      if (cmd_i.emit) begin
        match_q[hi_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_i;
    end
    if (cmd_i.add | cmd_i.rm_done | cmd_i.emit) begin
      res_q <= res_d;
    end
    if (cmd_i.add && (add_status == STS_OK)) begin
      table_q[cnt_q[IDX_W-1:0]] <= '{id: req_q.watcher_id, thr: req_q.threshold_s, idle: 1'b0};
    end
    if (cmd_i.rm_step && rm_hit) begin
      for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
        if (CNT_W'(j) >= scan_k_q) begin
          table_q[j] <= table_q[j+1];
        end
      end
    end
    if (cmd_i.scan_step) begin
      if (is_tick) begin
        if (!rd_entry.idle && entry_due) begin
          table_q[scan_idx].idle <= 1'b1;
        end
      end else begin
        table_q[scan_idx].idle <= 1'b0;
      end
    end
  end

  assign sts_o.any_idle   = any_idle_q;
  assign sts_o.is_tick    = is_tick;
  assign sts_o.req_bad    = req_bad;
  assign sts_o.found      = found_q;
  assign sts_o.scan_done  = (scan_k_q == cnt_q);
  assign sts_o.div_busy   = div_busy;
  assign sts_o.tick_due   = (nss_q != NONE_PENDING) && (IDLE_MS_W'(nss_q) <= secs);
  assign sts_o.match_none = (match_q == '0);
  assign sts_o.match_one  = ((match_q & (match_q - TABLE_DEPTH'(1))) == '0);

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ src/mtin_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle notifier controller
// State machine that sequences add, remove, division, table scan and
// notification output through datapath commands.
// ----------------------------------------------------------------------------
module mtin_ctrl
  import mtin_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  mtin_kind_e kind_i,
  input  mtin_sts_t  sts_i,
  output mtin_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (kind_i)
            KIND_ADD:      state_d = S_ADD;
            KIND_REMOVE:   state_d = S_RM;
            KIND_ACTIVITY: state_d = sts_i.any_idle ? S_DIV_GO : S_IDLE;
            KIND_TICK:     state_d = S_DIV_GO;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_IDLE;
      end
      S_RM: begin
        if (sts_i.req_bad || sts_i.found || sts_i.scan_done) begin
          cmd_o.rm_done = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.rm_step = 1'b1;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          if (sts_i.is_tick && !sts_i.tick_due) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts_i.match_none) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.emit = 1'b1;
          if (sts_i.match_one) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

@@ src/multi_threshold_idle_notifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-threshold idle notifier
// Watcher table with idle thresholds, a saturating idle timer and ordered
// idle and active notifications.
// ----------------------------------------------------------------------------
// A transaction is taken on a rising edge with start high and busy low; the
// fields arrive in in_i. Each result is presented on res_o for one cycle with
// res_valid_o high, and the receiver must take it then; it cannot stall.
// Add gives its status result. Remove searches the table entry by entry
// before it gives its status result. A tick or an activity that has work to
// do divides the idle time by the milliseconds per second at four quotient
// bits per cycle, then scans the table at one entry per cycle, then sends
// one notification per cycle in descending table order. A tick that reaches
// no threshold and an activity with no idle watcher end after the divider or
// at once, with no result. The division and the single table read port set
// this pace. One transaction is in work at a time. Reset empties the table,
// clears the idle time and idle state and leaves no switch pending; table
// contents are not cleared.
// ----------------------------------------------------------------------------
`include "multi_threshold_idle_notifier_defines.svh"

module multi_threshold_idle_notifier
  import mtin_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  mtin_in_t  in_i,
  output logic      res_valid_o,
  output mtin_res_t res_o
);

  mtin_cmd_t cmd;
  mtin_sts_t sts;

  mtin_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (in_i.kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  mtin_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  `MTIN_ASSERT_NXT(a_add_goes_busy, start && !busy && (in_i.kind == KIND_ADD), busy, "add transaction did not start work")
  `MTIN_ASSERT_IMP(a_status_single, res_valid_o && (res_o.event_res == EV_STATUS), res_o.last && (res_o.reported_s == '0), "status result malformed")
  `MTIN_ASSERT_IMP(a_result_from_work, res_valid_o, $past(busy), "result without a transaction in work")
  `MTIN_ASSERT_IMP(a_emit_has_match, cmd.emit, !sts.match_none, "notification with no pending match")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-threshold idle notifier
// Drives add, remove, activity and tick transactions through the start/busy
// handshake. A behavioral copy of the watcher table, idle timer and pending
// switch predicts every status and notification. A checker compares each
// strobed result with the oldest prediction. Directed tests cover argument
// checks, a full table, duplicate entries and timer saturation. A long random
// mix with some malformed requests runs before the saturation test.
// ----------------------------------------------------------------------------
module tb_top;
  import mtin_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 64;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  mtin_in_t  in_i;
  logic      res_valid_o;
  mtin_res_t res_o;

  mtin_entry_t          tab_entries [TABLE_DEPTH];
  int                   tab_count;
  logic [IDLE_MS_W-1:0] idle_ms_acc;
  bit                   idle_flag_seen;
  logic [SWITCH_W-1:0]  next_due_s;

  mtin_res_t notices_due [$];
  int        mismatches;
  int        cycles;
  int        calm_left;

  multi_threshold_idle_notifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic void note_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  task automatic push_notice(input logic [ID_W-1:0] id, input mtin_event_e ev,
                             input logic [AMT_W-1:0] rep, input mtin_status_e sts,
                             input logic last);
    mtin_res_t r;
    r.watcher_id_out = id;
    r.event_res      = ev;
    r.reported_s     = rep;
    r.status         = sts;
    r.last           = last;
    notices_due.push_back(r);
  endtask

  task automatic predict_notices(input mtin_in_t req);
    logic [ID_W-1:0]      hits [$];
    logic [IDLE_MS_W:0]   sum;
    logic [IDLE_MS_W-1:0] secs;
    logic [AMT_W-1:0]     rep;
    mtin_event_e          ev;
    mtin_status_e         sts;
    int                   found;
    int                   i;
    ev = EV_STATUS;
    rep = '0;
    case (req.kind)
      KIND_ADD: begin
        if (req.watcher_id == 0 || req.threshold_s == 0) begin
          sts = STS_BAD_ARG;
        end else if (tab_count >= TABLE_DEPTH) begin
          sts = STS_FULL;
        end else begin
          tab_entries[tab_count].id   = req.watcher_id;
          tab_entries[tab_count].thr  = req.threshold_s;
          tab_entries[tab_count].idle = 1'b0;
          tab_count++;
          if (next_due_s > req.threshold_s) begin
            next_due_s = req.threshold_s;
          end
          sts = STS_OK;
        end
        push_notice(req.watcher_id, EV_STATUS, '0, sts, 1'b1);
      end
      KIND_REMOVE: begin
        sts = STS_NOT_FOUND;
        found = -1;
        if (req.watcher_id == 0 || req.threshold_s == 0) begin
          sts = STS_BAD_ARG;
        end else begin
          for (i = 0; i < tab_count; i++) begin
            if (found < 0 && tab_entries[i].id == req.watcher_id &&
                tab_entries[i].thr == req.threshold_s) begin
              found = i;
            end
          end
          if (found >= 0) begin
            for (i = found; i < tab_count - 1; i++) begin
              tab_entries[i] = tab_entries[i + 1];
            end
            tab_count--;
            sts = STS_OK;
          end
        end
        push_notice(req.watcher_id, EV_STATUS, '0, sts, 1'b1);
      end
      KIND_ACTIVITY: begin
        idle_ms_acc = req.amount_ms;
        if (idle_flag_seen) begin
          next_due_s = NONE_PENDING;
          for (i = 0; i < tab_count; i++) begin
            if (tab_entries[i].idle) begin
              hits.push_back(tab_entries[i].id);
              tab_entries[i].idle = 1'b0;
            end
            if (tab_entries[i].thr < next_due_s) begin
              next_due_s = tab_entries[i].thr;
            end
          end
          idle_flag_seen = 1'b0;
          ev = EV_ACTIVE;
          rep = req.amount_ms / MS_PER_SECOND;
        end
      end
      default: begin
        sum = {1'b0, idle_ms_acc} + req.amount_ms;
        idle_ms_acc = sum[IDLE_MS_W] ? '1 : sum[IDLE_MS_W-1:0];
        secs = idle_ms_acc / MS_PER_SECOND;
        if (next_due_s != NONE_PENDING && next_due_s <= secs) begin
          next_due_s = NONE_PENDING;
          for (i = 0; i < tab_count; i++) begin
            if (!tab_entries[i].idle) begin
              if (tab_entries[i].thr <= secs) begin
                hits.push_back(tab_entries[i].id);
                tab_entries[i].idle = 1'b1;
                idle_flag_seen = 1'b1;
              end else if (tab_entries[i].thr < next_due_s) begin
                next_due_s = tab_entries[i].thr;
              end
            end
          end
          ev = EV_IDLE;
          rep = (secs > 40'hFFFFFFFF) ? '1 : secs[AMT_W-1:0];
        end
      end
    endcase
    for (i = hits.size() - 1; i >= 0; i--) begin
      push_notice(hits[i], ev, rep, STS_OK, i == 0);
    end
  endtask

  task automatic send_request(input mtin_kind_e kind, input logic [ID_W-1:0] id,
                              input logic [THR_W-1:0] thr, input logic [AMT_W-1:0] amt);
    mtin_in_t req;
    int       gap;
    req.kind        = kind;
    req.watcher_id  = id;
    req.threshold_s = thr;
    req.amount_ms   = amt;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) begin
        calm_left = $urandom_range(8, 24);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= req;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_notices(req);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (notices_due.size() != 0);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 19) == 0) return '0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 255);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    if ($urandom_range(0, 19) == 0) return '0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 24'hFFFFFF);
    return $urandom_range(1, 45);
  endfunction

  task automatic test_request_checks();
    send_request(KIND_TICK, $urandom, $urandom, 32'd5000);
    send_request(KIND_ACTIVITY, $urandom, $urandom, 32'd0);
    send_request(KIND_ADD, 8'd0, 24'd5, $urandom);
    send_request(KIND_ADD, 8'd9, 24'd0, $urandom);
    send_request(KIND_REMOVE, 8'd0, 24'd0, $urandom);
    send_request(KIND_REMOVE, 8'd9, 24'd5, $urandom);
    send_request(KIND_ADD, 8'd255, 24'hFFFFFF, 32'hFFFFFFFF);
  endtask

  task automatic test_table_limits();
    int k;
    for (k = 0; k < 14; k++) begin
      send_request(KIND_ADD, k + 1, (k % 4) + 1, $urandom);
    end
    send_request(KIND_ADD, 8'd3, 24'd3, $urandom);
    send_request(KIND_ADD, 8'd77, 24'd2, $urandom);
    send_request(KIND_TICK, $urandom, $urandom, 32'd2500);
    send_request(KIND_TICK, $urandom, $urandom, 32'd3000);
    send_request(KIND_ACTIVITY, $urandom, $urandom, 32'd1500);
    send_request(KIND_REMOVE, 8'd3, 24'd3, $urandom);
  endtask

  task automatic test_random_mix(input int n);
    int k;
    int pick;
    int sel;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 39) begin
        hold_until_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_request(KIND_ADD, pick_id(), pick_threshold(), $urandom);
      end else if (pick < 55) begin
        if (tab_count > 0 && $urandom_range(0, 3) != 0) begin
          sel = $urandom_range(0, tab_count - 1);
          send_request(KIND_REMOVE, tab_entries[sel].id, tab_entries[sel].thr, $urandom);
        end else begin
          send_request(KIND_REMOVE, pick_id(), pick_threshold(), $urandom);
        end
      end else if (pick < 85) begin
        send_request(KIND_TICK, $urandom, $urandom,
                     ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 20000));
      end else begin
        send_request(KIND_ACTIVITY, $urandom, $urandom,
                     ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 9000));
      end
    end
  endtask

  task automatic test_timer_saturation();
    int k;
    hold_until_drained();
    send_request(KIND_ACTIVITY, $urandom, $urandom, 32'd0);
    while (tab_count > 0) begin
      send_request(KIND_REMOVE, tab_entries[0].id, tab_entries[0].thr, $urandom);
    end
    send_request(KIND_ADD, 8'd200, 24'hFFFFFF, $urandom);
    for (k = 0; k < 260; k++) begin
      send_request(KIND_TICK, $urandom, $urandom, 32'hFFFFFFFF);
    end
    send_request(KIND_ADD, 8'd201, 24'd1, $urandom);
    send_request(KIND_TICK, $urandom, $urandom, 32'd0);
    send_request(KIND_ACTIVITY, $urandom, $urandom, 32'hFFFFFFFF);
  endtask

  always @(posedge clk_i) begin
    mtin_res_t want;
    if (rst_ni && res_valid_o) begin
      if (notices_due.size() == 0) begin
        note_fault($sformatf("unexpected result id=%0d ev=%0d rep=%0d sts=%0d last=%0d",
                             res_o.watcher_id_out, res_o.event_res, res_o.reported_s,
                             res_o.status, res_o.last));
      end else begin
        want = notices_due.pop_front();
        if (res_o.watcher_id_out !== want.watcher_id_out ||
            res_o.event_res !== want.event_res || res_o.reported_s !== want.reported_s ||
            res_o.status !== want.status || res_o.last !== want.last) begin
          note_fault($sformatf({"mismatch exp id=%0d ev=%0d rep=%0d sts=%0d last=%0d",
                                " got id=%0d ev=%0d rep=%0d sts=%0d last=%0d"},
                               want.watcher_id_out, want.event_res, want.reported_s,
                               want.status, want.last, res_o.watcher_id_out,
                               res_o.event_res, res_o.reported_s, res_o.status,
                               res_o.last));
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cycles = 0;
    mismatches = 0;
    calm_left = 0;
    tab_count = 0;
    idle_ms_acc = '0;
    idle_flag_seen = 1'b0;
    next_due_s = NONE_PENDING;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_request_checks();
    test_table_limits();
    test_random_mix(230);
    test_timer_saturation();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (notices_due.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", notices_due.size()));
    end
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/mtin_pkg.sv
src/mtin_div.sv
src/mtin_datapath.sv
src/mtin_ctrl.sv
src/multi_threshold_idle_notifier.sv
tb/sv/tb_top.sv
